FILE: src/ast_pkg.sv
// shared types and constants for the address state table
// used by ast_mem, ast_ctrl and address_state_table; no dependencies
package ast_pkg;

  localparam int SLOTS      = 12;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int ADDR_W     = 48;
  localparam int KEY_W      = ADDR_W + 1;
  localparam int STATE_W    = 8;
  localparam int SLOT_OUT_W = 4;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_SET    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ctrl_state_t;

  // request from the controller to the entry memory
  typedef struct packed {
    logic               re;
    logic [IDX_W-1:0]   raddr;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [KEY_W-1:0]   wkey;
    logic [STATE_W-1:0] wstate;
  } mem_req_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STATE_W-1:0] state;
  } mem_rd_t;

  typedef struct packed {
    logic [STATE_W-1:0]    read_state;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot_used;
  } result_t;

  // empty flag on top, address bits cleared for an empty key
  function automatic logic [KEY_W-1:0] make_key(input logic [ADDR_W-1:0] addr,
                                                input logic empty);
    logic [KEY_W-1:0] k;
    if (empty) begin
      k = {1'b1, {ADDR_W{1'b0}}};
    end else begin
      k = {1'b0, addr};
    end
    return k;
  endfunction

endpackage

FILE: src/ast_mem.sv
// entry memory: one key and one state per slot, one write and one read port
// read data is registered; depends on ast_pkg
module ast_mem (
  input  logic             clk,
  input  ast_pkg::mem_req_t req,
  output ast_pkg::mem_rd_t  rd
);

  ast_pkg::mem_rd_t entries [ast_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      entries[req.waddr] <= '{key: req.wkey, state: req.wstate};
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd <= entries[req.raddr];
    end
  end

endmodule

FILE: src/ast_ctrl.sv
// scan controller: walks the filled slots through the entry memory,
// then on a set updates the hit, appended or last slot; depends on ast_pkg
module ast_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [ast_pkg::ADDR_W-1:0]    key_addr,
  input  logic                          key_empty,
  input  logic [ast_pkg::STATE_W-1:0]   new_state,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ast_pkg::result_t              res,
  output ast_pkg::mem_req_t             mem_req,
  input  ast_pkg::mem_rd_t              mem_rd
);

  ast_pkg::ctrl_state_t state, state_next;

  logic                          cur_mode;
  logic [ast_pkg::KEY_W-1:0]     cur_key;
  logic [ast_pkg::STATE_W-1:0]   cur_state;
  logic [ast_pkg::CNT_W-1:0]     idx;
  logic                          cmp_valid;
  logic [ast_pkg::IDX_W-1:0]     cmp_idx;
  logic                          found;
  logic [ast_pkg::IDX_W-1:0]     found_idx;
  logic [ast_pkg::STATE_W-1:0]   found_st;
  logic [ast_pkg::CNT_W-1:0]     fill;

  logic                          accept;
  logic                          skip_scan;
  logic                          match;
  logic                          last_miss;
  logic                          issue;
  logic [ast_pkg::IDX_W-1:0]     wr_slot;
  logic                          finish;

  assign accept    = in_valid && (state == ast_pkg::ST_IDLE);
  // empty-key lookups and an empty table need no scan
  assign skip_scan = ((mode == ast_pkg::MODE_LOOKUP) && key_empty) ||
                     (fill == '0);
  assign match     = cmp_valid && (mem_rd.key == cur_key);
  assign last_miss = cmp_valid && !match &&
                     (ast_pkg::CNT_W'(cmp_idx) == fill - ast_pkg::CNT_W'(1));
  assign issue     = (state == ast_pkg::ST_SCAN) && (idx < fill);
  assign finish    = (state == ast_pkg::ST_DONE) && res_ready;

  always_comb begin
    if (found) begin
      wr_slot = found_idx;
    end else if (fill < ast_pkg::CNT_W'(ast_pkg::SLOTS)) begin
      wr_slot = fill[ast_pkg::IDX_W-1:0];
    end else begin
      wr_slot = ast_pkg::IDX_W'(ast_pkg::SLOTS - 1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ast_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = skip_scan ? ast_pkg::ST_DONE : ast_pkg::ST_SCAN;
        end
      end
      ast_pkg::ST_SCAN: begin
        if (match || last_miss) begin
          state_next = ast_pkg::ST_DONE;
        end
      end
      ast_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = ast_pkg::ST_IDLE;
        end
      end
      default: state_next = ast_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = (state == ast_pkg::ST_IDLE);
    res_valid      = (state == ast_pkg::ST_DONE);
    mem_req.re     = issue;
    mem_req.raddr  = idx[ast_pkg::IDX_W-1:0];
    mem_req.we     = finish && (cur_mode == ast_pkg::MODE_SET);
    mem_req.waddr  = wr_slot;
    mem_req.wkey   = cur_key;
    mem_req.wstate = cur_state;
    if (cur_mode == ast_pkg::MODE_SET) begin
      res.read_state = cur_state;
      res.hit        = found;
      res.slot_used  = ast_pkg::SLOT_OUT_W'(wr_slot);
    end else if (found) begin
      res.read_state = found_st;
      res.hit        = 1'b1;
      res.slot_used  = ast_pkg::SLOT_OUT_W'(found_idx);
    end else begin
      res.read_state = '0;
      res.hit        = 1'b0;
      res.slot_used  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ast_pkg::ST_IDLE;
      fill      <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cmp_valid <= 1'b0;
        found     <= 1'b0;
      end else if (state == ast_pkg::ST_SCAN) begin
        cmp_valid <= issue;
        if (match) begin
          found <= 1'b1;
        end
      end
      // a miss on set appends while there is room
      if (finish && (cur_mode == ast_pkg::MODE_SET) && !found &&
          (fill < ast_pkg::CNT_W'(ast_pkg::SLOTS))) begin
        fill <= fill + ast_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_mode  <= mode;
      cur_key   <= ast_pkg::make_key(key_addr, key_empty);
      cur_state <= new_state;
      idx       <= '0;
    end else if (state == ast_pkg::ST_SCAN) begin
      if (issue) begin
        idx <= idx + ast_pkg::CNT_W'(1);
      end
      cmp_idx <= idx[ast_pkg::IDX_W-1:0];
      if (match) begin
        found_idx <= cmp_idx;
        found_st  <= mem_rd.state;
      end
    end
  end

endmodule

FILE: src/address_state_table.sv
// top level of the address state table: controller, entry memory and
// output register; depends on ast_pkg, ast_mem, ast_ctrl
//
//  channel | handshake           | payload
//  in      | in_valid, in_ready  | mode, key_addr, key_empty, new_state
//  out     | out_valid, out_ready| read_state, hit, slot_used
//
// an item goes from accept through the scan and the done state into the output
// register; the scan reads the filled slots (at most 12) one slot per cycle
// from the single-read-port entry memory, and a hit ends it at the matching
// slot. an empty-key lookup or an empty table skips the scan. one item is in
// work at a time; the next is taken while a result waits in the output
// register, and a second result stalls the controller until out_ready. reset
// clears the fill count and control state only; slot contents are never read
// before they are written.
module address_state_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [ast_pkg::ADDR_W-1:0]  key_addr,
  input  logic                        key_empty,
  input  logic [ast_pkg::STATE_W-1:0] new_state,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ast_pkg::STATE_W-1:0] read_state,
  output logic                        hit,
  output logic [ast_pkg::SLOT_OUT_W-1:0] slot_used
);

  ast_pkg::mem_req_t mem_req;
  ast_pkg::mem_rd_t  mem_rd;
  ast_pkg::result_t  res;
  logic              res_valid;
  logic              res_ready;

  ast_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .key_addr  (key_addr),
    .key_empty (key_empty),
    .new_state (new_state),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rd    (mem_rd)
  );

  ast_mem u_mem (
    .clk (clk),
    .req (mem_req),
    .rd  (mem_rd)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      read_state <= res.read_state;
      hit        <= res.hit;
      slot_used  <= res.slot_used;
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// testbench for the address state table: directed and random set/lookup items
// checked against a behavioral copy of the table; depends on ast_pkg and
// address_state_table
module tb;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic                           mode;
  logic [ast_pkg::ADDR_W-1:0]     key_addr;
  logic                           key_empty;
  logic [ast_pkg::STATE_W-1:0]    new_state;
  logic                           out_valid;
  logic                           out_ready;
  logic [ast_pkg::STATE_W-1:0]    read_state;
  logic                           hit;
  logic [ast_pkg::SLOT_OUT_W-1:0] slot_used;

  address_state_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .key_addr(key_addr), .key_empty(key_empty), .new_state(new_state),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_state(read_state), .hit(hit), .slot_used(slot_used)
  );

  localparam logic [ast_pkg::ADDR_W-1:0] ADDR_ONES = {ast_pkg::ADDR_W{1'b1}};
  localparam logic [ast_pkg::ADDR_W-1:0] ADDR_ODD  = 48'h5555_5555_5555;
  localparam logic [ast_pkg::ADDR_W-1:0] ADDR_EVEN = 48'hAAAA_AAAA_AAAA;
  localparam logic [ast_pkg::ADDR_W-1:0] ADDR_NEAR = ADDR_ONES - ast_pkg::ADDR_W'(1);
  localparam int RANDOM_ITEMS = 1150;

  // behavioral copy of the table
  logic [ast_pkg::KEY_W-1:0]   shadow_key [ast_pkg::SLOTS];
  logic [ast_pkg::STATE_W-1:0] shadow_state [ast_pkg::SLOTS];
  int                          shadow_fill;

  ast_pkg::result_t results_due[$];
  bit      gaps_on;
  bit      stalls_on;
  int      mismatches;
  int      orphans;
  int      n_items, n_sets, n_hits, n_replaced, n_empty;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d results still pending", results_due.size());
    $display("status: fail");
    $finish;
  end

  function automatic logic [ast_pkg::ADDR_W-1:0] rand_addr();
    return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // applies one item to the shadow table and returns the result it must give
  function automatic ast_pkg::result_t table_apply(logic m,
                                                   logic [ast_pkg::ADDR_W-1:0] a,
                                                   logic e,
                                                   logic [ast_pkg::STATE_W-1:0] s);
    ast_pkg::result_t          r;
    logic [ast_pkg::KEY_W-1:0] k;
    int                        found;
    int                        w;
    k = e ? {1'b1, {ast_pkg::ADDR_W{1'b0}}} : {1'b0, a};
    found = -1;
    for (int i = 0; i < shadow_fill; i++) begin
      if (found < 0 && shadow_key[i] == k) found = i;
    end
    r = '0;
    if (m == ast_pkg::MODE_LOOKUP) begin
      // an empty key never matches on lookup, even once stored
      if (!e && found >= 0) begin
        r.read_state = shadow_state[found];
        r.hit        = 1'b1;
        r.slot_used  = ast_pkg::SLOT_OUT_W'(found);
      end
    end else begin
      n_sets++;
      if (found >= 0) begin
        w = found;
        r.hit = 1'b1;
      end else begin
        if (shadow_fill < ast_pkg::SLOTS) begin
          w = shadow_fill;
          shadow_fill++;
        end else begin
          w = ast_pkg::SLOTS - 1;
          n_replaced++;
        end
        shadow_key[w] = k;
      end
      shadow_state[w] = s;
      r.read_state = s;
      r.slot_used  = ast_pkg::SLOT_OUT_W'(w);
    end
    if (r.hit) n_hits++;
    if (e) n_empty++;
    return r;
  endfunction

  task automatic send_item(logic m, logic [ast_pkg::ADDR_W-1:0] a, logic e,
                           logic [ast_pkg::STATE_W-1:0] s);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    mode      = m;
    key_addr  = a;
    key_empty = e;
    new_state = s;
    do @(posedge clk); while (!in_ready);
    results_due.push_back(table_apply(m, a, e, s));
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    ast_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        orphans++;
        if (mismatches + orphans <= 10)
          $display("unexpected result: state %0d hit %0d slot %0d",
                   read_state, hit, slot_used);
      end else begin
        want = results_due.pop_front();
        if (read_state !== want.read_state || hit !== want.hit ||
            slot_used !== want.slot_used) begin
          mismatches++;
          if (mismatches + orphans <= 10)
            $display("mismatch at %0t: state %0d/%0d hit %0d/%0d slot %0d/%0d (exp/got)",
                     $time, want.read_state, read_state, want.hit, hit,
                     want.slot_used, slot_used);
        end
      end
    end
  end

  // receiver back-pressure
  initial begin
    int run;
    out_ready = 1'b1;
    @(negedge clk);
    forever begin
      if (stalls_on) begin
        out_ready = 1'b0;
        run = pick_gap();
        repeat (run) @(negedge clk);
        out_ready = 1'b1;
        run = $urandom_range(1, 6);
        repeat (run) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // lookups on an empty table, then the empty key as a stored key
  task automatic test_empty_table();
    send_item(ast_pkg::MODE_LOOKUP, '0, 1'b0, 8'd7);
    send_item(ast_pkg::MODE_LOOKUP, ADDR_ONES, 1'b0, 8'd0);
    send_item(ast_pkg::MODE_LOOKUP, ADDR_ONES, 1'b1, 8'd0);
    send_item(ast_pkg::MODE_SET, rand_addr(), 1'b1, 8'd255);
    send_item(ast_pkg::MODE_LOOKUP, '0, 1'b1, 8'd0);
    send_item(ast_pkg::MODE_SET, ADDR_EVEN, 1'b1, 8'd0);
    drain();
  endtask

  // append until every slot is used, with address and state extremes
  task automatic test_fill();
    send_item(ast_pkg::MODE_SET, '0, 1'b0, 8'd0);
    send_item(ast_pkg::MODE_SET, ADDR_ONES, 1'b0, 8'd255);
    send_item(ast_pkg::MODE_SET, ADDR_ODD, 1'b0, 8'd128);
    send_item(ast_pkg::MODE_SET, ADDR_EVEN, 1'b0, 8'd1);
    while (shadow_fill < ast_pkg::SLOTS)
      send_item(ast_pkg::MODE_SET, rand_addr(), 1'b0, 8'($urandom()));
    send_item(ast_pkg::MODE_LOOKUP, '0, 1'b0, 8'd99);
    send_item(ast_pkg::MODE_LOOKUP, ADDR_ONES, 1'b0, 8'd0);
    send_item(ast_pkg::MODE_LOOKUP, shadow_key[ast_pkg::SLOTS-1][ast_pkg::ADDR_W-1:0],
              1'b0, 8'd0);
    send_item(ast_pkg::MODE_SET, ADDR_ODD, 1'b0, 8'd254);
    drain();
  endtask

  // misses on a full table replace the last slot
  task automatic test_overflow();
    logic [ast_pkg::ADDR_W-1:0] old_last;
    old_last = shadow_key[ast_pkg::SLOTS-1][ast_pkg::ADDR_W-1:0];
    send_item(ast_pkg::MODE_SET, ADDR_NEAR, 1'b0, 8'd77);
    send_item(ast_pkg::MODE_LOOKUP, old_last, 1'b0, 8'd0);
    send_item(ast_pkg::MODE_LOOKUP, ADDR_NEAR, 1'b0, 8'd0);
    drain();
  endtask

  // random items over a small address pool so keys recur and hit
  task automatic test_random();
    logic [ast_pkg::ADDR_W-1:0] pool [16];
    logic [ast_pkg::ADDR_W-1:0] a;
    logic                       e;
    int                         r;
    pool[0] = '0;
    pool[1] = ADDR_ONES;
    for (int i = 2; i < 16; i++) pool[i] = rand_addr();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // alternate stretches with and without idling
      if (n % 200 == 0) begin
        gaps_on   = (n % 400 == 0);
        stalls_on = (n % 600 != 0);
      end
      r = $urandom_range(0, 99);
      e = (r >= 90);
      a = (r < 70 || r >= 90) ? pool[$urandom_range(0, 15)] : rand_addr();
      if (e && $urandom_range(0, 1)) a = rand_addr();
      send_item(logic'($urandom_range(0, 1)), a, e, 8'($urandom()));
    end
    drain();
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    mode      = ast_pkg::MODE_LOOKUP;
    key_addr  = '0;
    key_empty = 1'b0;
    new_state = '0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    shadow_fill = 0;
    mismatches = 0;
    orphans    = 0;
    n_items = 0; n_sets = 0; n_hits = 0; n_replaced = 0; n_empty = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_fill();
    test_overflow();
    test_random();

    $display("%0d items: %0d sets, %0d lookups, %0d hits, %0d empty keys",
             n_items, n_sets, n_items - n_sets, n_hits, n_empty);
    $display("%0d last-slot replacements on a full table; %0d mismatches, %0d unexpected",
             n_replaced, mismatches, orphans);
    if (mismatches == 0 && orphans == 0 && results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
